/* hw/rtl/mrpr_pkg.sv */
// Package with the sequencer state type for the primality round block.
package mrpr_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SPLIT,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_CHECK,
    ST_SQUARE,
    ST_SQ_CHECK,
    ST_OUT
  } state_t;

endpackage

/* hw/rtl/miller_rabin_primality_round_top.sv */
// Top level of the Miller-Rabin round: sequencer around a shared modular multiplier.
// Each modular multiplication runs on the bit-serial multiplier; an item needs up to
// about 2*NUM_BITS multiplications. The witness is first reduced by restoring division;
// a trivial candidate gives its result in the cycle after its transfer. One item is in
// work at a time; the result register frees when the transfer occurs. Synchronous reset
// returns the sequencer to idle and the running verdict to pass.
module miller_rabin_primality_round_top #(
  parameter int NUM_BITS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [30:0]         candidate,
  input  logic [30:0]         witness,
  input  logic                last_witness,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                round_verdict,
  output logic                run_verdict,
  output logic                run_done
);

  localparam int NB = NUM_BITS;
  localparam int SW = $clog2(NB + 1);

  mrpr_pkg::state_t state;
  mrpr_pkg::state_t state_next;

  logic [NB-1:0] n;
  logic [NB-1:0] nm1;
  logic [NB-1:0] x;
  logic [NB-1:0] b;
  logic [NB-1:0] d;
  logic [NB-1:0] rem;
  logic [NB-1:0] wq;
  logic [SW-1:0] s;
  logic [SW-1:0] r;
  logic [SW-1:0] rcnt;
  logic          last;
  logic          verdict;
  logic          pass_so_far;
  logic          mm_start;
  logic          mm_busy;
  logic          mm_done;
  logic [NB-1:0] mm_a;
  logic [NB-1:0] mm_b;
  logic [NB-1:0] mm_p;
  logic [NB-1:0] cand_w;
  logic [NB-1:0] wit_w;
  logic          accept;
  logic          trivial;
  logic          triv_res;
  logic [NB:0]   rem_sh;

  assign cand_w = NB'(candidate);
  assign wit_w = NB'(witness);
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != mrpr_pkg::ST_IDLE) || out_valid;
  assign nm1 = n - 1'b1;
  assign trivial = (cand_w < NB'(4)) || !cand_w[0];
  assign triv_res = (cand_w == NB'(2)) || (cand_w == NB'(3));
  assign rem_sh = {rem, wq[NB-1]};

  mrpr_modmul #(.NUM_BITS(NB)) u_mul (
    .clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b), .m(n),
    .busy(mm_busy), .done(mm_done), .p(mm_p)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mrpr_pkg::ST_IDLE:
        if (accept && !trivial) state_next = mrpr_pkg::ST_REDUCE;
      mrpr_pkg::ST_REDUCE:
        if (rcnt == '0) state_next = mrpr_pkg::ST_SPLIT;
      mrpr_pkg::ST_SPLIT:
        if (d[0]) state_next = mrpr_pkg::ST_POW_MUL;
      mrpr_pkg::ST_POW_MUL:
        if (d == '0) state_next = mrpr_pkg::ST_CHECK;
        else if (mm_done || !d[0]) state_next = mrpr_pkg::ST_POW_SQR;
      mrpr_pkg::ST_POW_SQR:
        if (mm_done) state_next = mrpr_pkg::ST_POW_MUL;
      mrpr_pkg::ST_CHECK:
        if (x == NB'(1) || x == nm1 || r >= s) state_next = mrpr_pkg::ST_OUT;
        else state_next = mrpr_pkg::ST_SQUARE;
      mrpr_pkg::ST_SQUARE:
        if (mm_done) state_next = mrpr_pkg::ST_SQ_CHECK;
      mrpr_pkg::ST_SQ_CHECK:
        if (x == nm1 || (r + 1'b1) >= s) state_next = mrpr_pkg::ST_OUT;
        else state_next = mrpr_pkg::ST_SQUARE;
      mrpr_pkg::ST_OUT:
        state_next = mrpr_pkg::ST_IDLE;
      default: state_next = mrpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mm_start = 1'b0;
    mm_a = x;
    mm_b = b;
    unique case (state)
      mrpr_pkg::ST_POW_MUL:
        mm_start = !mm_busy && !mm_done && d[0];
      mrpr_pkg::ST_POW_SQR: begin
        mm_a = b;
        mm_start = !mm_busy && !mm_done;
      end
      mrpr_pkg::ST_SQUARE: begin
        mm_b = x;
        mm_start = !mm_busy && !mm_done;
      end
      default: mm_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrpr_pkg::ST_IDLE;
      out_valid <= 1'b0;
      pass_so_far <= 1'b1;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if ((accept && trivial) || state == mrpr_pkg::ST_OUT) begin
        out_valid <= 1'b1;
        pass_so_far <= (accept && trivial) ? (last_witness | (pass_so_far & triv_res))
                                           : (last | (pass_so_far & verdict));
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mrpr_pkg::ST_IDLE:
        if (accept) begin
          n <= cand_w;
          wq <= wit_w;
          rem <= '0;
          rcnt <= SW'(NB);
          last <= last_witness;
          d <= cand_w - 1'b1;
          s <= '0;
          r <= SW'(1);
          verdict <= 1'b0;
          round_verdict <= triv_res;
          run_verdict <= pass_so_far & triv_res;
          run_done <= last_witness;
        end
      mrpr_pkg::ST_REDUCE: begin
        // Restoring division, one quotient bit per cycle, leaves witness mod n.
        if (rcnt != '0) begin
          rcnt <= rcnt - 1'b1;
          wq <= {wq[NB-2:0], 1'b0};
          rem <= (rem_sh >= {1'b0, n}) ? NB'(rem_sh - {1'b0, n}) : rem_sh[NB-1:0];
        end
        x <= NB'(1);
      end
      mrpr_pkg::ST_SPLIT: begin
        b <= rem;
        if (!d[0]) begin
          d <= d >> 1;
          s <= s + 1'b1;
        end
      end
      mrpr_pkg::ST_POW_MUL:
        if (mm_done) x <= mm_p;
      mrpr_pkg::ST_POW_SQR:
        if (mm_done) begin
          b <= mm_p;
          d <= d >> 1;
        end
      mrpr_pkg::ST_CHECK:
        if (x == NB'(1) || x == nm1) verdict <= 1'b1;
      mrpr_pkg::ST_SQUARE:
        if (mm_done) x <= mm_p;
      mrpr_pkg::ST_SQ_CHECK: begin
        r <= r + 1'b1;
        if (x == nm1) verdict <= 1'b1;
      end
      mrpr_pkg::ST_OUT: begin
        round_verdict <= verdict;
        run_verdict <= pass_so_far & verdict;
        run_done <= last;
      end
      default: ;
    endcase
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != mrpr_pkg::ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    (state == mrpr_pkg::ST_OUT) |=> out_valid) else $error("result lost");
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    (state == mrpr_pkg::ST_IDLE) |-> !mm_start) else $error("stray multiply");

endmodule

/* hw/rtl/mrpr_modmul.sv */
// Shift-and-add modular multiplier, one multiplier bit per cycle.
module mrpr_modmul #(
  parameter int NUM_BITS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] a,
  input  logic [NUM_BITS-1:0] b,
  input  logic [NUM_BITS-1:0] m,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] p
);

  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] acc;
  logic [NUM_BITS-1:0] acc_next;
  logic [NUM_BITS-1:0] mult;
  logic [NUM_BITS-1:0] base;
  logic [NUM_BITS-1:0] modulus;
  logic [CW-1:0]       count;
  logic [NUM_BITS+1:0] dbl;
  logic [NUM_BITS+1:0] dbl_red;
  logic [NUM_BITS+1:0] sum;

  // Horner step from the top bit: acc = 2*acc + bit*base, each reduced once.
  always_comb begin
    dbl = {1'b0, acc, 1'b0};
    dbl_red = (dbl >= {2'b00, modulus}) ? dbl - {2'b00, modulus} : dbl;
    sum = dbl_red + (mult[NUM_BITS-1] ? {2'b00, base} : '0);
    if (sum >= {2'b00, modulus}) begin
      sum = sum - {2'b00, modulus};
    end
    acc_next = sum[NUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(NUM_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mult <= a;
      base <= b;
      modulus <= m;
    end else if (busy) begin
      acc <= acc_next;
      mult <= {mult[NUM_BITS-2:0], 1'b0};
    end
  end

  assign p = acc;

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the Miller-Rabin round block: random and directed candidates checked by a scoreboard.
`timescale 1ns / 1ps

class verdict_board;
  bit exp_round[$];
  bit exp_run[$];
  bit exp_done[$];
  bit pass_so_far;
  int errors;
  int checked;

  function new();
    pass_so_far = 1'b1;
    errors = 0;
    checked = 0;
  endfunction

  function bit [63:0] mulmod(bit [63:0] x, bit [63:0] y, bit [63:0] m);
    return (x * y) % m;
  endfunction

  function bit round_passes(bit [63:0] n, bit [63:0] a);
    bit [63:0] d;
    bit [63:0] x;
    bit [63:0] b;
    bit [63:0] e;
    int s;
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    d = n - 1;
    s = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      s++;
    end
    x = 1;
    b = a % n;
    e = d;
    while (e > 0) begin
      if (e[0]) x = mulmod(x, b, n);
      b = mulmod(b, b, n);
      e = e >> 1;
    end
    if (x == 1 || x == n - 1) return 1'b1;
    for (int r = 1; r < s; r++) begin
      x = mulmod(x, x, n);
      if (x == n - 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void note_input(bit [30:0] n, bit [30:0] a, bit last);
    bit rv;
    bit run;
    rv = round_passes({33'd0, n}, {33'd0, a});
    run = pass_so_far & rv;
    pass_so_far = last ? 1'b1 : run;
    exp_round = {exp_round, rv};
    exp_run = {exp_run, run};
    exp_done = {exp_done, last};
  endfunction

  function void check_result(bit rv, bit run, bit done);
    checked++;
    if (exp_round.size() == 0) begin
      $display("%0t: unexpected result round=%0b run=%0b done=%0b", $time, rv, run, done);
      errors++;
      return;
    end
    if (exp_round[0] !== rv) begin
      $display("%0t: round_verdict expected %0b actual %0b", $time, exp_round[0], rv);
      errors++;
    end
    if (exp_run[0] !== run) begin
      $display("%0t: run_verdict expected %0b actual %0b", $time, exp_run[0], run);
      errors++;
    end
    if (exp_done[0] !== done) begin
      $display("%0t: run_done expected %0b actual %0b", $time, exp_done[0], done);
      errors++;
    end
    void'(exp_round.pop_front());
    void'(exp_run.pop_front());
    void'(exp_done.pop_front());
  endfunction
endclass

module tb_top;
  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [30:0] candidate;
  logic [30:0] witness;
  logic last_witness;
  logic out_valid;
  logic out_stall;
  logic round_verdict;
  logic run_verdict;
  logic run_done;

  verdict_board board;
  bit stim_done;
  bit hold_off;
  bit held;
  int sent;

  miller_rabin_primality_round_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .candidate(candidate), .witness(witness), .last_witness(last_witness),
    .out_valid(out_valid), .out_stall(out_stall),
    .round_verdict(round_verdict), .run_verdict(run_verdict), .run_done(run_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(bit [30:0] n, bit [30:0] a, bit last);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    candidate <= n;
    witness <= a;
    last_witness <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(n, a, last);
    sent++;
  endtask

  task automatic send_run(bit [30:0] n, int count);
    bit [30:0] a;
    for (int i = 0; i < count; i++) begin
      if (n > 4) a = 31'($urandom_range(2, n - 2));
      else a = 31'($urandom);
      send_item(n, a, i == count - 1);
    end
  endtask

  function automatic bit [30:0] odd_small();
    return 31'($urandom_range(2, 4000) * 2 + 1);
  endfunction

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    candidate = '0;
    witness = '0;
    last_witness = 1'b0;
    stim_done = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_item(31'd0, 31'd5, 1'b0);
    send_item(31'd1, 31'h7fffffff, 1'b1);
    send_item(31'd2, 31'd0, 1'b0);
    send_item(31'd3, 31'h7fffffff, 1'b1);
    send_item(31'd4, 31'd3, 1'b1);
    send_item(31'h7ffffffe, 31'd7, 1'b1);
    send_item(31'h7fffffff, 31'd2, 1'b0);
    send_item(31'h7fffffff, 31'h7ffffffe, 1'b0);
    send_item(31'h7fffffff, 31'h7fffffff, 1'b1);
    send_item(31'd97, 31'd194, 1'b0);
    send_item(31'd97, 31'd98, 1'b0);
    send_item(31'd97, 31'd96, 1'b1);
    send_item(31'd561, 31'd2, 1'b0);
    send_item(31'd561, 31'd50, 1'b1);
    send_item(31'd5, 31'h55555555, 1'b1);
    send_item(31'd2047, 31'd2, 1'b1);
    send_item(31'h2aaaaaab, 31'h15555555, 1'b1);
    send_item(31'd65537, 31'd3, 1'b1);
    hold_off = 1'b1;
    send_run(31'd101, 4);
    hold_off = 1'b0;
    while (sent < 200) begin
      case ($urandom_range(0, 9))
        0: send_item(31'($urandom), 31'($urandom), 1'($urandom));
        1: send_run(31'($urandom) | 31'd1, $urandom_range(1, 3));
        2: send_item(31'($urandom_range(0, 9)), 31'($urandom), 1'($urandom));
        default: send_run(odd_small(), $urandom_range(1, 5));
      endcase
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int gap;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      if (hold_off && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (4000) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      if (out_valid && !out_stall) begin
        board.check_result(round_verdict, run_verdict, run_done);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (board.exp_round.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d candidate/witness items, checked %0d verdicts,", sent, board.checked);
    $display("including trivial, edge-width and multi-witness runs with output back-pressure.");
    if (board.errors == 0 && board.exp_round.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
